### hdl/menu_and_alarm_clock_controller_defines.svh
// Assertion macros for the menu and alarm clock controller.
// Used by the top level only; needs clock and reset in scope.
`ifndef MENU_AND_ALARM_CLOCK_CONTROLLER_DEFINES_SVH
`define MENU_AND_ALARM_CLOCK_CONTROLLER_DEFINES_SVH

// antecedent holds -> consequent in the same cycle
`define MACC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("macc: same-cycle check failed");

// antecedent holds -> consequent in the next cycle
`define MACC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("macc: next-cycle check failed");

`endif

### hdl/macc_pkg.sv
// Types and constants for the menu and alarm clock controller.
// No dependencies.
`default_nettype none

package macc_pkg;

   localparam int FLOOR_COUNT = 5;

   localparam logic [15:0] TPS_RESET    = 16'd1000;
   localparam logic [4:0]  HOUR_RESET   = 5'd12;
   localparam logic [4:0]  OPEN_RESET   = 5'd8;
   localparam logic [4:0]  CLOSE_RESET  = 5'd22;
   localparam logic [3:0]  FLOOR_RESET  = 4'd1;
   localparam logic [4:0]  HOUR_MAX     = 5'd23;
   localparam logic [5:0]  MINSEC_MAX   = 6'd59;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_MODE     = 3'd1,
      CMD_FLOOR    = 3'd2,
      CMD_ACTUATOR = 3'd3,
      CMD_SWITCH   = 3'd4,
      CMD_LOAD     = 3'd5,
      CMD_REMOTE   = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_MONITOR = 2'd0,
      MODE_CONTROL = 2'd1,
      MODE_ALARM   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REQ_NONE        = 3'd0,
      REQ_QUERY       = 3'd1,
      REQ_SET         = 3'd2,
      REQ_OPEN_ALARM  = 3'd3,
      REQ_CLOSE_ALARM = 3'd4
   } req_type;

endpackage

`default_nettype wire

### hdl/menu_and_alarm_clock_controller.sv
// Menu and alarm clock controller.
// The result is registered: it becomes valid in the cycle after the item is accepted.
// Throughput: 1 item per cycle while the result side keeps up; all state updates settle in one combinational pass.
// Output register decouples the sides: a new item is taken while the result is taken.
// Reset (synchronous): clock 12:00:00, monitor mode, floor 1, alarms 08:00 / 22:00.
`default_nettype none
`include "menu_and_alarm_clock_controller_defines.svh"

module menu_and_alarm_clock_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // command [2:0]
   input  wire logic [2:0]  req_tuser,
   // load_hour, load_minute, load_second, remote_floor, remote_kind, remote_on
   input  wire logic [23:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // request, time_request, shown_mode, shown_floor, shown_kind, shown_on,
   // shown_alarm_select, now_hour, now_minute, now_second,
   // alarm_hour_shown, alarm_minute_shown, zero pad
   output      logic [47:0] rsp_tdata,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [15:0] csr_data
);
   import macc_pkg::*;

   logic [15:0] tps_ff;
   logic [15:0] tick_ff, tick_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   mode_type    mode_ff, mode_in;
   logic [3:0]  floor_ff, floor_in;
   logic [1:0]  kind_ff, kind_in;
   logic        on_ff, on_in;
   logic        asel_ff, asel_in;
   logic [4:0]  open_hour_ff, open_hour_in;
   logic [5:0]  open_minute_ff, open_minute_in;
   logic [4:0]  close_hour_ff, close_hour_in;
   logic [5:0]  close_minute_ff, close_minute_in;
   req_type     request_in;
   logic        treq_in;

   logic        rsp_valid_ff;
   req_type     rsp_request_ff;
   logic        rsp_treq_ff;
   mode_type    rsp_mode_ff;
   logic [3:0]  rsp_floor_ff;
   logic [1:0]  rsp_kind_ff;
   logic        rsp_on_ff;
   logic        rsp_asel_ff;
   logic [4:0]  rsp_hour_ff;
   logic [5:0]  rsp_minute_ff;
   logic [5:0]  rsp_second_ff;
   logic [4:0]  rsp_ahour_ff;
   logic [5:0]  rsp_aminute_ff;

   logic        accept;
   logic [4:0]  ld_hour;
   logic [5:0]  ld_minute;
   logic [5:0]  ld_second;
   logic [3:0]  rm_floor;
   logic [1:0]  rm_kind;
   logic        rm_on;
   logic [15:0] tick_inc;

   function automatic logic [3:0] floor_step(input logic [3:0] f, input logic ctl);
      logic [3:0] r;
      r = f;
      for (int i = 0; i < 16; i++) begin
         if (f == 4'(i)) begin
            r = ctl ? 4'((i + 1) % (FLOOR_COUNT + 1)) : 4'((i % FLOOR_COUNT) + 1);
         end
      end
      return r;
   endfunction

   function automatic logic [4:0] hour_step(input logic [4:0] h);
      return (h >= HOUR_MAX) ? 5'd0 : h + 5'd1;
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign ld_hour   = req_tdata[4:0];
   assign ld_minute = req_tdata[10:5];
   assign ld_second = req_tdata[16:11];
   assign rm_floor  = req_tdata[20:17];
   assign rm_kind   = req_tdata[22:21];
   assign rm_on     = req_tdata[23];
   assign tick_inc  = tick_ff + 16'd1;

   always_comb begin
      tick_in         = tick_ff;
      hour_in         = hour_ff;
      minute_in       = minute_ff;
      second_in       = second_ff;
      mode_in         = mode_ff;
      floor_in        = floor_ff;
      kind_in         = kind_ff;
      on_in           = on_ff;
      asel_in         = asel_ff;
      open_hour_in    = open_hour_ff;
      open_minute_in  = open_minute_ff;
      close_hour_in   = close_hour_ff;
      close_minute_in = close_minute_ff;
      request_in      = REQ_NONE;
      treq_in         = 1'b0;
      unique case (cmd_type'(req_tuser))
         CMD_TICK: begin
            tick_in = tick_inc;
            if (tick_inc >= tps_ff) begin
               tick_in = '0;
               if (second_ff >= MINSEC_MAX) begin
                  second_in = '0;
                  if (minute_ff >= MINSEC_MAX) begin
                     minute_in = '0;
                     if (hour_ff >= HOUR_MAX) begin
                        hour_in = '0;
                        treq_in = 1'b1;
                     end else begin
                        hour_in = hour_ff + 5'd1;
                     end
                  end else begin
                     minute_in = minute_ff + 6'd1;
                  end
                  if (hour_in == open_hour_ff && minute_in == open_minute_ff) begin
                     request_in = REQ_OPEN_ALARM;
                  end else if (hour_in == close_hour_ff && minute_in == close_minute_ff) begin
                     request_in = REQ_CLOSE_ALARM;
                  end
               end else begin
                  second_in = second_ff + 6'd1;
               end
            end
         end
         CMD_MODE: begin
            treq_in = 1'b1;
            unique case (mode_ff)
               MODE_MONITOR: begin
                  mode_in = MODE_CONTROL;
                  if (floor_ff == 4'd0) begin
                     floor_in = FLOOR_RESET;
                  end
               end
               MODE_CONTROL: mode_in = MODE_ALARM;
               MODE_ALARM: begin
                  mode_in    = MODE_MONITOR;
                  request_in = REQ_QUERY;
               end
               default: begin
                  mode_in = MODE_CONTROL;
                  if (floor_ff == 4'd0) begin
                     floor_in = FLOOR_RESET;
                  end
               end
            endcase
         end
         CMD_FLOOR: begin
            priority if (mode_ff == MODE_MONITOR) begin
               floor_in = floor_step(floor_ff, 1'b0);
            end else if (mode_ff == MODE_CONTROL) begin
               floor_in   = floor_step(floor_ff, 1'b1);
               request_in = REQ_QUERY;
            end else begin
               asel_in = !asel_ff;
            end
         end
         CMD_ACTUATOR: begin
            if (mode_ff == MODE_CONTROL) begin
               kind_in    = kind_ff + 2'd1;
               request_in = REQ_QUERY;
            end else if (mode_ff == MODE_ALARM) begin
               if (!asel_ff) begin
                  open_hour_in = hour_step(open_hour_ff);
               end else begin
                  close_hour_in = hour_step(close_hour_ff);
               end
            end
         end
         CMD_SWITCH: begin
            if (mode_ff == MODE_CONTROL) begin
               on_in      = !on_ff;
               request_in = REQ_SET;
            end else if (mode_ff == MODE_ALARM) begin
               if (!asel_ff) begin
                  if (open_minute_ff >= MINSEC_MAX) begin
                     open_minute_in = '0;
                     open_hour_in   = hour_step(open_hour_ff);
                  end else begin
                     open_minute_in = open_minute_ff + 6'd1;
                  end
               end else begin
                  if (close_minute_ff >= MINSEC_MAX) begin
                     close_minute_in = '0;
                     close_hour_in   = hour_step(close_hour_ff);
                  end else begin
                     close_minute_in = close_minute_ff + 6'd1;
                  end
               end
            end
         end
         CMD_LOAD: begin
            hour_in   = (ld_hour > HOUR_MAX) ? HOUR_MAX : ld_hour;
            minute_in = (ld_minute > MINSEC_MAX) ? MINSEC_MAX : ld_minute;
            second_in = (ld_second > MINSEC_MAX) ? MINSEC_MAX : ld_second;
         end
         CMD_REMOTE: begin
            floor_in = rm_floor;
            kind_in  = rm_kind;
            on_in    = rm_on;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff          <= TPS_RESET;
         tick_ff         <= '0;
         hour_ff         <= HOUR_RESET;
         minute_ff       <= '0;
         second_ff       <= '0;
         mode_ff         <= MODE_MONITOR;
         floor_ff        <= FLOOR_RESET;
         kind_ff         <= '0;
         on_ff           <= 1'b0;
         asel_ff         <= 1'b0;
         open_hour_ff    <= OPEN_RESET;
         open_minute_ff  <= '0;
         close_hour_ff   <= CLOSE_RESET;
         close_minute_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            tps_ff <= csr_data;
         end
         if (accept) begin
            tick_ff         <= tick_in;
            hour_ff         <= hour_in;
            minute_ff       <= minute_in;
            second_ff       <= second_in;
            mode_ff         <= mode_in;
            floor_ff        <= floor_in;
            kind_ff         <= kind_in;
            on_ff           <= on_in;
            asel_ff         <= asel_in;
            open_hour_ff    <= open_hour_in;
            open_minute_ff  <= open_minute_in;
            close_hour_ff   <= close_hour_in;
            close_minute_ff <= close_minute_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_request_ff <= request_in;
         rsp_treq_ff    <= treq_in;
         rsp_mode_ff    <= mode_in;
         rsp_floor_ff   <= floor_in;
         rsp_kind_ff    <= kind_in;
         rsp_on_ff      <= on_in;
         rsp_asel_ff    <= asel_in;
         rsp_hour_ff    <= hour_in;
         rsp_minute_ff  <= minute_in;
         rsp_second_ff  <= second_in;
         rsp_ahour_ff   <= asel_in ? close_hour_in : open_hour_in;
         rsp_aminute_ff <= asel_in ? close_minute_in : open_minute_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_aminute_ff, rsp_ahour_ff, rsp_second_ff, rsp_minute_ff,
                        rsp_hour_ff, rsp_asel_ff, rsp_on_ff, rsp_kind_ff, rsp_floor_ff,
                        rsp_mode_ff, rsp_treq_ff, rsp_request_ff};

   `MACC_ASSERT_NEXT(a_accept_gives_item, accept, rsp_valid_ff)
   `MACC_ASSERT_SAME(a_clock_in_range, rsp_valid_ff,
      rsp_hour_ff <= HOUR_MAX && rsp_minute_ff <= MINSEC_MAX && rsp_second_ff <= MINSEC_MAX)
   `MACC_ASSERT_SAME(a_alarm_on_minute, rsp_valid_ff &&
      (rsp_request_ff == REQ_OPEN_ALARM || rsp_request_ff == REQ_CLOSE_ALARM),
      rsp_second_ff == 6'd0)
   `MACC_ASSERT_NEXT(a_tick_treq_midnight, accept && req_tuser == CMD_TICK,
      !rsp_treq_ff || (rsp_hour_ff == 5'd0 && rsp_minute_ff == 6'd0))

endmodule

`default_nettype wire

### dv/testbench.sv
// Testbench for menu_and_alarm_clock_controller: a directed table, then random phases.
// Checks every result field by field: table rows give their view, others are predicted.
// Depends on macc_pkg and the controller RTL.
module testbench;
   import macc_pkg::*;

   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam int PHASE_ITEMS = 125;

   typedef struct packed {
      logic       remote_on;
      logic [1:0] remote_kind;
      logic [3:0] remote_floor;
      logic [5:0] load_second;
      logic [5:0] load_minute;
      logic [4:0] load_hour;
   } panel_input_type;

   // highest field first: request sits in the low bits
   typedef struct packed {
      logic [5:0] sel_minute;
      logic [4:0] sel_hour;
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic       alarm_sel;
      logic       on;
      logic [1:0] kind;
      logic [3:0] floor_sel;
      mode_type   mode;
      logic       time_req;
      req_type    request;
   } panel_view_type;

   typedef struct packed {
      logic [2:0]      cmd;
      panel_input_type data;
      logic            typed;
      panel_view_type  view;
   } script_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // panel state as predicted
   logic [15:0] tps = TPS_RESET;
   logic [15:0] tick_cnt = '0;
   logic [4:0]  hh = HOUR_RESET;
   logic [5:0]  mm = '0;
   logic [5:0]  ss = '0;
   mode_type    mode = MODE_MONITOR;
   logic [3:0]  floor_sel = FLOOR_RESET;
   logic [1:0]  kind = '0;
   logic        on = 1'b0;
   logic        alarm_sel = 1'b0;
   logic [4:0]  open_h = OPEN_RESET;
   logic [5:0]  open_m = '0;
   logic [4:0]  close_h = CLOSE_RESET;
   logic [5:0]  close_m = '0;

   panel_view_type pending_views[$];
   int          errors = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   menu_and_alarm_clock_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("menu_and_alarm_clock_controller test failed");
      $finish;
   end

   function automatic logic [4:0] bump_hour(input logic [4:0] h);
      return (h == HOUR_MAX) ? 5'd0 : h + 5'd1;
   endfunction

   function automatic panel_input_type pack_in(input logic [4:0] h, input logic [5:0] m,
                                               input logic [5:0] s, input logic [3:0] f,
                                               input logic [1:0] k, input logic o);
      return {o, k, f, s, m, h};
   endfunction

   function automatic script_row_type row(input logic [2:0] cmd, input panel_input_type d,
                                          input logic typed, input panel_view_type v);
      return {cmd, d, typed, v};
   endfunction

   function automatic panel_view_type advance_panel(input logic [2:0] cmd,
                                                    input panel_input_type d);
      panel_view_type v;
      req_type     rq;
      logic        treq;
      int          f;
      rq = REQ_NONE;
      treq = 1'b0;
      f = floor_sel;
      case (cmd)
         CMD_TICK: begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= tps) begin
               tick_cnt = '0;
               if (ss == MINSEC_MAX) begin
                  ss = '0;
                  if (mm == MINSEC_MAX) begin
                     mm = '0;
                     if (hh == HOUR_MAX) begin
                        hh = '0;
                        treq = 1'b1;
                     end else begin
                        hh = hh + 5'd1;
                     end
                  end else begin
                     mm = mm + 6'd1;
                  end
               end else begin
                  ss = ss + 6'd1;
               end
               if (ss == 0) begin
                  if (hh == open_h && mm == open_m)
                     rq = REQ_OPEN_ALARM;
                  else if (hh == close_h && mm == close_m)
                     rq = REQ_CLOSE_ALARM;
               end
            end
         end
         CMD_MODE: begin
            case (mode)
               MODE_MONITOR: mode = MODE_CONTROL;
               MODE_CONTROL: mode = MODE_ALARM;
               default:      mode = MODE_MONITOR;
            endcase
            if (mode == MODE_MONITOR)
               rq = REQ_QUERY;
            else if (mode == MODE_CONTROL && floor_sel == 0)
               floor_sel = 4'd1;
            treq = 1'b1;
         end
         CMD_FLOOR: begin
            if (mode == MODE_MONITOR) begin
               floor_sel = 4'((f % FLOOR_COUNT) + 1);
            end else if (mode == MODE_CONTROL) begin
               floor_sel = 4'((f + 1) % (FLOOR_COUNT + 1));
               rq = REQ_QUERY;
            end else begin
               alarm_sel = ~alarm_sel;
            end
         end
         CMD_ACTUATOR: begin
            if (mode == MODE_CONTROL) begin
               kind = kind + 2'd1;
               rq = REQ_QUERY;
            end else if (mode == MODE_ALARM) begin
               if (alarm_sel) close_h = bump_hour(close_h);
               else open_h = bump_hour(open_h);
            end
         end
         CMD_SWITCH: begin
            if (mode == MODE_CONTROL) begin
               on = ~on;
               rq = REQ_SET;
            end else if (mode == MODE_ALARM) begin
               if (alarm_sel) begin
                  if (close_m == MINSEC_MAX) begin
                     close_m = '0;
                     close_h = bump_hour(close_h);
                  end else begin
                     close_m = close_m + 6'd1;
                  end
               end else begin
                  if (open_m == MINSEC_MAX) begin
                     open_m = '0;
                     open_h = bump_hour(open_h);
                  end else begin
                     open_m = open_m + 6'd1;
                  end
               end
            end
         end
         CMD_LOAD: begin
            hh = (d.load_hour > HOUR_MAX) ? HOUR_MAX : d.load_hour;
            mm = (d.load_minute > MINSEC_MAX) ? MINSEC_MAX : d.load_minute;
            ss = (d.load_second > MINSEC_MAX) ? MINSEC_MAX : d.load_second;
         end
         CMD_REMOTE: begin
            floor_sel = d.remote_floor;
            kind = d.remote_kind;
            on = d.remote_on;
         end
         default: ;
      endcase
      v.request = rq;
      v.time_req = treq;
      v.mode = mode;
      v.floor_sel = floor_sel;
      v.kind = kind;
      v.on = on;
      v.alarm_sel = alarm_sel;
      v.hour = hh;
      v.minute = mm;
      v.second = ss;
      v.sel_hour = alarm_sel ? close_h : open_h;
      v.sel_minute = alarm_sel ? close_m : open_m;
      return v;
   endfunction

   function automatic void report(input string name, input int e, input int a);
      if (e != a) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
         errors++;
      end
   endfunction

   function automatic void compare_view(input panel_view_type e, input panel_view_type a);
      report("request", int'(e.request), int'(a.request));
      report("time_request", e.time_req, a.time_req);
      report("shown_mode", int'(e.mode), int'(a.mode));
      report("shown_floor", e.floor_sel, a.floor_sel);
      report("shown_kind", e.kind, a.kind);
      report("shown_on", e.on, a.on);
      report("shown_alarm_select", e.alarm_sel, a.alarm_sel);
      report("now_hour", e.hour, a.hour);
      report("now_minute", e.minute, a.minute);
      report("now_second", e.second, a.second);
      report("alarm_hour_shown", e.sel_hour, a.sel_hour);
      report("alarm_minute_shown", e.sel_minute, a.sel_minute);
   endfunction

   task automatic send_item(input logic [2:0] cmd, input panel_input_type d,
                            input logic typed, input panel_view_type typed_view);
      panel_view_type v;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      v = advance_panel(cmd, d);
      pending_views.push_back(typed ? typed_view : v);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_tps(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tps = value;
   endtask

   // result side
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_views.size() == 0) begin
               $display("%0t: result with none expected, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               compare_view(pending_views.pop_front(), panel_view_type'(rsp_tdata[41:0]));
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      script_row_type  script[$];
      logic [15:0]     tps_plan[8];
      logic [2:0]      cmd;
      panel_input_type d;
      int              sent;
      int              r;
      int              n;
      int              mins;

      tps_plan = '{16'd1, 16'd0, 16'd2, 16'd65535, 16'd1, 16'd3, 16'd1, 16'd7};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // view order: alarm min, alarm hour, sec, min, hour, sel, on, kind, floor, mode, treq, req
      script.push_back(row(CMD_TICK, '0, 1'b1, panel_view_type'({6'd0, 5'd8, 6'd0, 6'd0, 5'd12,
         1'b0, 1'b0, 2'd0, 4'd1, MODE_MONITOR, 1'b0, REQ_NONE})));
      script.push_back(row(CMD_LOAD, pack_in(5'd31, 6'd63, 6'd63, 4'd0, 2'd0, 1'b0), 1'b1,
         panel_view_type'({6'd0, 5'd8, 6'd59, 6'd59, 5'd23,
         1'b0, 1'b0, 2'd0, 4'd1, MODE_MONITOR, 1'b0, REQ_NONE})));
      script.push_back(row(CMD_LOAD, pack_in(5'd0, 6'd0, 6'd0, 4'd15, 2'd3, 1'b1), 1'b1,
         panel_view_type'({6'd0, 5'd8, 6'd0, 6'd0, 5'd0,
         1'b0, 1'b0, 2'd0, 4'd1, MODE_MONITOR, 1'b0, REQ_NONE})));
      script.push_back(row(CMD_UNUSED, '1, 1'b1, panel_view_type'({6'd0, 5'd8, 6'd0, 6'd0, 5'd0,
         1'b0, 1'b0, 2'd0, 4'd1, MODE_MONITOR, 1'b0, REQ_NONE})));
      // floor 0 and out-of-range floor 15 set remotely, then stepped
      script.push_back(row(CMD_REMOTE, pack_in(5'd31, 6'd63, 6'd63, 4'd0, 2'd3, 1'b1), 1'b1,
         panel_view_type'({6'd0, 5'd8, 6'd0, 6'd0, 5'd0,
         1'b0, 1'b1, 2'd3, 4'd0, MODE_MONITOR, 1'b0, REQ_NONE})));
      script.push_back(row(CMD_FLOOR, '0, 1'b0, '0));
      script.push_back(row(CMD_REMOTE, pack_in(5'd0, 6'd0, 6'd0, 4'd15, 2'd2, 1'b0), 1'b0, '0));
      script.push_back(row(CMD_FLOOR, '1, 1'b0, '0));
      script.push_back(row(CMD_REMOTE, pack_in(5'd0, 6'd0, 6'd0, 4'd0, 2'd1, 1'b1), 1'b0, '0));
      script.push_back(row(CMD_MODE, '0, 1'b0, '0));
      script.push_back(row(CMD_REMOTE, pack_in(5'd0, 6'd0, 6'd0, 4'd15, 2'd0, 1'b1), 1'b0, '0));
      script.push_back(row(CMD_FLOOR, '0, 1'b0, '0));
      script.push_back(row(CMD_ACTUATOR, '0, 1'b0, '0));
      script.push_back(row(CMD_SWITCH, '0, 1'b0, '0));
      script.push_back(row(CMD_MODE, '0, 1'b0, '0));
      script.push_back(row(CMD_FLOOR, '0, 1'b0, '0));
      // close alarm round past midnight onto the open alarm
      for (int i = 0; i < 10; i++)
         script.push_back(row(CMD_ACTUATOR, '0, 1'b0, '0));
      script.push_back(row(CMD_MODE, '0, 1'b0, '0));
      script.push_back(row(CMD_ACTUATOR, '1, 1'b0, '0));
      script.push_back(row(CMD_SWITCH, '1, 1'b0, '0));

      foreach (script[i])
         send_item(script[i].cmd, script[i].data, script[i].typed, script[i].view);

      for (int p = 0; p < 8; p++) begin
         drain();
         write_tps(tps_plan[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (sent == PHASE_ITEMS / 2)
               drain();
            d = 24'($urandom());
            if (mode == MODE_ALARM && $urandom_range(0, 99) < 3) begin
               // a run of minute steps that may carry into the hour
               n = $urandom_range(55, 70);
               for (int i = 0; i < n; i++) begin
                  d = 24'($urandom());
                  send_item(CMD_SWITCH, d, 1'b0, '0);
               end
               sent += n;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 45) begin
                  cmd = CMD_TICK;
               end else if (r < 55) begin
                  // one second short of an alarm or of midnight
                  cmd = CMD_LOAD;
                  case ($urandom_range(0, 2))
                     0: mins = open_h * 60 + open_m;
                     1: mins = close_h * 60 + close_m;
                     default: mins = 0;
                  endcase
                  mins = (mins + 1439) % 1440;
                  d.load_hour = 5'(mins / 60);
                  d.load_minute = 6'(mins % 60);
                  d.load_second = MINSEC_MAX;
               end else if (r < 62) cmd = CMD_LOAD;
               else if (r < 70) cmd = CMD_MODE;
               else if (r < 78) cmd = CMD_FLOOR;
               else if (r < 84) cmd = CMD_ACTUATOR;
               else if (r < 92) cmd = CMD_SWITCH;
               else if (r < 98) cmd = CMD_REMOTE;
               else cmd = CMD_UNUSED;
               send_item(cmd, d, 1'b0, '0);
               sent++;
            end
         end
      end

      drain();
      if (errors == 0) begin
         $display("menu_and_alarm_clock_controller test passed");
      end else begin
         $display("menu_and_alarm_clock_controller test failed");
      end
      $finish;
   end

endmodule
